// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is asserted.
`define HTFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication form: the consequent is checked in the cycle after the antecedent.
`define HTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/htfd_pkg.sv =====
package htfd_pkg;

  localparam int unsigned RAW_W      = 20;
  localparam int unsigned FRAC_SHIFT = 20;
  localparam int unsigned HUM_W      = 17;
  localparam int unsigned TEMP_W     = 19;

  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h31;

  localparam logic [16:0] HUM_SCALE   = 17'd100000;
  localparam logic [17:0] TEMP_SCALE  = 18'd200000;
  localparam logic [18:0] TEMP_OFFSET = 19'd50000;

  // Lowest and highest values the fields can take.
  localparam logic [16:0] HUM_MAX  = 17'd99999;
  localparam logic [18:0] TEMP_MIN = 19'h7_3CB0;  // -50000
  localparam logic [18:0] TEMP_MAX = 19'd149999;

  // Byte positions inside a response frame.
  localparam logic [2:0] POS_STATUS = 3'd0;
  localparam logic [2:0] POS_HUM_HI = 3'd1;
  localparam logic [2:0] POS_HUM_MD = 3'd2;
  localparam logic [2:0] POS_SPLIT  = 3'd3;
  localparam logic [2:0] POS_TMP_MD = 3'd4;
  localparam logic [2:0] POS_TMP_LO = 3'd5;
  localparam logic [2:0] POS_CRC    = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_e;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/humidity_temp_frame_decoder_unit.sv =====
// Response frame decoder for a humidity and temperature sensor.
// Input channel: one frame byte per transfer (in_valid_i/in_ready_o), with
// frame_start_i marking byte 0. A start mark on any byte drops a partial frame.
// Output channel: one result per completed seven-byte frame
// (out_valid_o/out_ready_i): status, humidity in millipercent and temperature
// in millidegrees Celsius, both fields zero unless the status is ok.
// Throughput: one byte per cycle while in_ready_o is high; the CRC update of a
// whole byte is unrolled combinational logic, and the two scaling multiplies
// sit in their own pipeline stage.
// The result of a frame enters the multiply stage when its seventh byte is
// taken, and moves on to the output stage once that stage can take it.
// Reset clears the byte count, CRC, busy bit and raw fields and empties both
// result stages. When the receiver stalls, the shown result holds; one more
// result waits in the multiply stage and in_ready_o drops only when both
// stages are full.
module humidity_temp_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        frame_start_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_code_o,
  output logic [16:0] humidity_milli_o,
  output logic signed [18:0] temperature_milli_o
);

  localparam int unsigned RawW  = htfd_pkg::RAW_W;
  localparam int unsigned HumPW = RawW + 17;
  localparam int unsigned TmpPW = RawW + 18;

  // Frame state.
  logic [2:0]      count_q, count_d;
  logic [7:0]      crc_q, crc_d;
  logic            busy_q, busy_d;
  logic [RawW-1:0] raw_h_q, raw_h_d;
  logic [RawW-1:0] raw_t_q, raw_t_d;

  // Multiply stage.
  logic              s1_valid_q;
  htfd_pkg::status_e s1_status_q;
  logic [16:0]       s1_hum_q;
  logic [17:0]       s1_tmp_q;

  // Output stage.
  logic              s2_valid_q;
  htfd_pkg::status_e s2_status_q;
  logic [16:0]       s2_hum_q;
  logic [18:0]       s2_tmp_q;

  logic in_xfer, s1_adv, s2_take, last_byte;
  logic [2:0]      pos;
  logic [7:0]      crc_cur;
  logic            busy_cur;
  logic [RawW-1:0] raw_h_cur, raw_t_cur;
  htfd_pkg::status_e status_new;
  logic [HumPW-1:0] hum_prod;
  logic [TmpPW-1:0] tmp_prod;

  assign s2_take    = !s2_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s2_take;
  assign in_ready_o = !s1_valid_q || s2_take;
  assign in_xfer    = in_valid_i && in_ready_o;

  // A start mark restarts the frame before the byte is taken.
  always_comb begin
    pos       = frame_start_i ? htfd_pkg::POS_STATUS : count_q;
    crc_cur   = frame_start_i ? htfd_pkg::CRC_INIT : crc_q;
    busy_cur  = frame_start_i ? 1'b0 : busy_q;
    raw_h_cur = frame_start_i ? '0 : raw_h_q;
    raw_t_cur = frame_start_i ? '0 : raw_t_q;
  end

  assign last_byte = (pos >= htfd_pkg::POS_CRC);

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    busy_d  = busy_q;
    raw_h_d = raw_h_q;
    raw_t_d = raw_t_q;
    if (in_xfer) begin
      if (last_byte) begin
        count_d = htfd_pkg::POS_STATUS;
        crc_d   = htfd_pkg::CRC_INIT;
        busy_d  = 1'b0;
        raw_h_d = '0;
        raw_t_d = '0;
      end else begin
        count_d = pos + 3'd1;
        crc_d   = htfd_pkg::crc8_byte(crc_cur, rx_byte_i);
        busy_d  = busy_cur;
        raw_h_d = raw_h_cur;
        raw_t_d = raw_t_cur;
        unique case (pos)
          htfd_pkg::POS_STATUS: busy_d = rx_byte_i[7];
          htfd_pkg::POS_HUM_HI: raw_h_d = {rx_byte_i, 12'h000};
          htfd_pkg::POS_HUM_MD: raw_h_d = raw_h_cur | {8'h00, rx_byte_i, 4'h0};
          htfd_pkg::POS_SPLIT: begin
            raw_h_d = raw_h_cur | {16'h0000, rx_byte_i[7:4]};
            raw_t_d = {rx_byte_i[3:0], 16'h0000};
          end
          htfd_pkg::POS_TMP_MD: raw_t_d = raw_t_cur | {4'h0, rx_byte_i, 8'h00};
          default: raw_t_d = raw_t_cur | {12'h000, rx_byte_i};
        endcase
      end
    end
  end

  // Busy wins over a CRC mismatch.
  always_comb begin
    priority if (busy_q) begin
      status_new = htfd_pkg::STATUS_BUSY;
    end else if (crc_q != rx_byte_i) begin
      status_new = htfd_pkg::STATUS_CRC_ERR;
    end else begin
      status_new = htfd_pkg::STATUS_OK;
    end
  end

  assign hum_prod = HumPW'(raw_h_q) * HumPW'(htfd_pkg::HUM_SCALE);
  assign tmp_prod = TmpPW'(raw_t_q) * TmpPW'(htfd_pkg::TEMP_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= htfd_pkg::POS_STATUS;
      crc_q   <= htfd_pkg::CRC_INIT;
      busy_q  <= 1'b0;
      raw_h_q <= '0;
      raw_t_q <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      busy_q  <= busy_d;
      raw_h_q <= raw_h_d;
      raw_t_q <= raw_t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_xfer && last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_byte) begin
      s1_status_q <= status_new;
      s1_hum_q    <= hum_prod[HumPW-1:htfd_pkg::FRAC_SHIFT];
      s1_tmp_q    <= tmp_prod[TmpPW-1:htfd_pkg::FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_take) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_status_q <= s1_status_q;
      if (s1_status_q == htfd_pkg::STATUS_OK) begin
        s2_hum_q <= s1_hum_q;
        s2_tmp_q <= {1'b0, s1_tmp_q} - htfd_pkg::TEMP_OFFSET;
      end else begin
        s2_hum_q <= '0;
        s2_tmp_q <= '0;
      end
    end
  end

  assign out_valid_o         = s2_valid_q;
  assign status_code_o       = s2_status_q;
  assign humidity_milli_o    = s2_hum_q;
  assign temperature_milli_o = s2_tmp_q;

endmodule

// ===== rtl/core/htfd_checker.sv =====
`include "assert_macros.svh"

module htfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_code_o,
  input logic [16:0] humidity_milli_o,
  input logic signed [18:0] temperature_milli_o
);

  logic        ok_shown;
  logic        code_known;
  logic        out_stalled;
  logic        fields_zero;
  logic        fields_in_range;
  logic [37:0] result_bits;

  assign ok_shown    = (status_code_o == htfd_pkg::STATUS_OK);
  assign code_known  = ok_shown || (status_code_o == htfd_pkg::STATUS_BUSY) ||
                       (status_code_o == htfd_pkg::STATUS_CRC_ERR);
  assign out_stalled = out_valid_o && !out_ready_i;
  assign result_bits = {status_code_o, humidity_milli_o, temperature_milli_o};
  assign fields_zero = (humidity_milli_o == '0) && (temperature_milli_o == '0);
  assign fields_in_range = (humidity_milli_o <= htfd_pkg::HUM_MAX) &&
                           (temperature_milli_o >= $signed(htfd_pkg::TEMP_MIN)) &&
                           (temperature_milli_o <= $signed(htfd_pkg::TEMP_MAX));

  // A stalled result keeps its payload.
  `HTFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled,
                    out_valid_o && $stable(result_bits), "stalled result changed")

  `HTFD_ASSERT(a_status_code, clk_i, rst_ni, !out_valid_o || code_known,
               "undefined status code")

  // Measurement fields are zero whenever the frame was rejected.
  `HTFD_ASSERT(a_zero_on_error, clk_i, rst_ni, !out_valid_o || ok_shown || fields_zero,
               "fields not zero on error")

  `HTFD_ASSERT(a_ranges, clk_i, rst_ni, !out_valid_o || fields_in_range,
               "measurement out of range")

  // With the output stage empty nothing can hold off the input.
  `HTFD_ASSERT(a_ready_when_empty, clk_i, rst_ni, out_valid_o || in_ready_o,
               "input stalled while output empty")

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_code_o       (status_code_o),
  .humidity_milli_o    (humidity_milli_o),
  .temperature_milli_o (temperature_milli_o)
);

// ===== bench/humidity_temp_frame_decoder_unit_test.sv =====
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_unit_test;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef logic [6:0][7:0] frame_t;

  typedef struct packed {
    htfd_pkg::status_e  status;
    logic [16:0]        hum;
    logic signed [18:0] temp;
  } reading_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic frame_start_i = 1'b0;
  logic [7:0] rx_byte_i = 8'd0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [1:0] status_code_o;
  logic [16:0] humidity_milli_o;
  logic signed [18:0] temperature_milli_o;

  // Predictor state, one copy of what the block keeps between bytes.
  logic [2:0]  frame_pos;
  logic [7:0]  frame_crc;
  logic        frame_busy;
  logic [19:0] frame_raw_hum;
  logic [19:0] frame_raw_temp;

  reading_t pending_readings[$];
  reading_t got_reading;
  reading_t want_reading;

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;

  humidity_temp_frame_decoder_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .frame_start_i       (frame_start_i),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_code_o       (status_code_o),
    .humidity_milli_o    (humidity_milli_o),
    .temperature_milli_o (temperature_milli_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bitwise CRC-8, MSB first: each data bit is folded into the feedback.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic frame_t build_frame(input logic [7:0] status_byte,
                                         input logic [19:0] raw_h,
                                         input logic [19:0] raw_t,
                                         input logic [7:0] crc_flip);
    frame_t f;
    logic [7:0] c;
    f[0] = status_byte;
    f[1] = raw_h[19:12];
    f[2] = raw_h[11:4];
    f[3] = {raw_h[3:0], raw_t[19:16]};
    f[4] = raw_t[15:8];
    f[5] = raw_t[7:0];
    c = htfd_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc8_update(c, f[i]);
    f[6] = c ^ crc_flip;
    return f;
  endfunction

  task automatic clear_frame_state();
    frame_pos = htfd_pkg::POS_STATUS;
    frame_crc = htfd_pkg::CRC_INIT;
    frame_busy = 1'b0;
    frame_raw_hum = '0;
    frame_raw_temp = '0;
  endtask

  // Advances the predictor by one accepted byte and queues the reading it completes.
  task automatic decode_byte(input logic start, input logic [7:0] b);
    reading_t r;
    logic [63:0] prod;
    if (start) clear_frame_state();
    if (frame_pos >= htfd_pkg::POS_CRC) begin
      r = '0;
      if (frame_busy) begin
        r.status = htfd_pkg::STATUS_BUSY;
      end else if (frame_crc != b) begin
        r.status = htfd_pkg::STATUS_CRC_ERR;
      end else begin
        r.status = htfd_pkg::STATUS_OK;
        prod = (64'(frame_raw_hum) * 64'd100000) >> htfd_pkg::FRAC_SHIFT;
        r.hum = prod[16:0];
        prod = ((64'(frame_raw_temp) * 64'd200000) >> htfd_pkg::FRAC_SHIFT) - 64'd50000;
        r.temp = prod[18:0];
      end
      pending_readings.push_back(r);
      clear_frame_state();
    end else begin
      frame_crc = crc8_update(frame_crc, b);
      case (frame_pos)
        htfd_pkg::POS_STATUS: frame_busy = b[7];
        htfd_pkg::POS_HUM_HI: frame_raw_hum = {b, 12'd0};
        htfd_pkg::POS_HUM_MD: frame_raw_hum[11:4] = b;
        htfd_pkg::POS_SPLIT: begin
          frame_raw_hum[3:0] = b[7:4];
          frame_raw_temp = {b[3:0], 16'd0};
        end
        htfd_pkg::POS_TMP_MD: frame_raw_temp[15:8] = b;
        default: frame_raw_temp[7:0] = b;
      endcase
      frame_pos = frame_pos + 3'd1;
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the transfer,
  // with valid possibly still high so that the next call can follow at once.
  task automatic send_byte(input logic start, input logic [7:0] b);
    in_valid_i <= 1'b1;
    frame_start_i <= start;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(start, b);
    bytes_sent++;
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input frame_t f, input logic mark_start);
    for (int i = 0; i < 7; i++) send_byte(mark_start && i == 0, f[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [19:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic test_field_extremes();
    // Lowest raw values with a start mark, then highest raw values with none:
    // after a completed frame the count is back at zero.
    send_frame(build_frame(8'h00, 20'h00000, 20'h00000, 8'h00), 1'b1);
    send_frame(build_frame(8'h7F, 20'hFFFFF, 20'hFFFFF, 8'h00), 1'b0);
  endtask

  task automatic test_busy_and_restart();
    // A partial frame is dropped by a new start mark; busy wins over a bad CRC.
    send_byte(1'b1, 8'h1C);
    send_byte(1'b0, 8'hA5);
    send_frame(build_frame(8'h80, 20'h5A5A5, 20'hA5A5A, 8'h01), 1'b1);
    send_frame(build_frame(8'hFF, 20'h12345, 20'h6789A, 8'h00), 1'b1);
  endtask

  task automatic test_crc_mismatch();
    send_frame(build_frame(8'h18, 20'h80000, 20'h66666, 8'hFF), 1'b1);
    drain();
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned target;
    int unsigned cut;
    frame_t f;
    logic [7:0] st;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      st = 8'($urandom);
      st[7] = ($urandom_range(0, 4) == 0);
      f = build_frame(st, pick_raw(), pick_raw(),
                      ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      case ($urandom_range(0, 9))
        0: send_byte(1'($urandom), 8'($urandom));
        1: begin
          cut = $urandom_range(1, 6);
          for (int i = 0; i < cut; i++) send_byte(i == 0, f[i]);
        end
        2: send_frame(f, 1'b0);
        3: for (int i = 0; i < 7; i++) send_byte(i == 0 || $urandom_range(0, 7) == 0, f[i]);
        default: send_frame(f, 1'b1);
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    sender_gaps = 1'b0;
    for (int k = 0; k < 10; k++)
      send_frame(build_frame(8'h1C, pick_raw(), pick_raw(), 8'h00), 1'b1);
    sender_gaps = 1'b1;
    drain();
  endtask

  task automatic test_steady_stream();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_frames(200);
    drain();
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_reading.status = htfd_pkg::status_e'(status_code_o);
      got_reading.hum = humidity_milli_o;
      got_reading.temp = temperature_milli_o;
      if (pending_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("ERROR: unexpected result status=%0d hum=%0d temp=%0d",
                   status_code_o, humidity_milli_o, temperature_milli_o);
        mismatch_count++;
      end else begin
        want_reading = pending_readings.pop_front();
        if (got_reading != want_reading) begin
          if (mismatch_count < 10)
            $display("ERROR: expected status=%0d hum=%0d temp=%0d, ",
                     want_reading.status, want_reading.hum, want_reading.temp,
                     "got status=%0d hum=%0d temp=%0d",
                     got_reading.status, got_reading.hum, got_reading.temp);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    clear_frame_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_busy_and_restart();
    test_crc_mismatch();
    test_random_frames(240);
    test_backpressure();
    test_random_frames(210);
    drain();
    test_steady_stream();
    if (pending_readings.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/htfd_pkg.sv
rtl/core/humidity_temp_frame_decoder_unit.sv
rtl/core/htfd_checker.sv
bench/humidity_temp_frame_decoder_unit_test.sv
